### sv/sei_pkg.sv
`default_nettype none
package sei_pkg;

   // sizing
   localparam int MAX_PAYLOAD = 1024;
   localparam int LEN_W       = 11;
   localparam int SIZE_W      = ($clog2(MAX_PAYLOAD + 17) > 9) ?
                                $clog2(MAX_PAYLOAD + 17) : 9;
   localparam int REQ_DATA_W  = 24;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   // byte constants of the nal unit
   localparam logic [7:0] NAL_SEI   = 8'h06;
   localparam logic [7:0] SEI_UDU   = 8'h05;
   localparam logic [7:0] TRAIL     = 8'h80;
   localparam logic [7:0] EPB       = 8'h03;
   localparam logic [7:0] BYTE_FF   = 8'hFF;
   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam logic [7:0] BYTE_ONE  = 8'h01;

   // register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] REG_UUID0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_UUID1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_UUID2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_UUID3 = 2'd3;
   localparam logic [31:0] UUID0_RST = 32'h3F8A2B1C;
   localparam logic [31:0] UUID1_RST = 32'h4D5E6F70;
   localparam logic [31:0] UUID2_RST = 32'h8192A3B4;
   localparam logic [31:0] UUID3_RST = 32'hC5D6E7F8;

   // request kinds
   localparam logic ACT_BEGIN = 1'b0;
   localparam logic ACT_BYTE  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_LEN   = 2'd1,
      ST_NOMSG = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_HDR, S_TYPE, S_SIZE, S_UUID,
      S_DATA, S_TRAIL, S_ERR_LEN, S_ERR_MSG
   } state_type;

   typedef enum logic [2:0] {
      SRC_START, SRC_HDR, SRC_TYPE, SRC_SIZE,
      SRC_UUID, SRC_DATA, SRC_TRAIL, SRC_ERR
   } src_type;

   typedef struct packed {
      logic       cap_begin;
      logic       cap_byte;
      logic       emit;
      logic       esc;
      logic       last;
      status_type status;
      src_type    src;
      logic       size_step;
      logic       cnt_clr;
      logic       cnt_inc;
      logic       byte_done;
   } dp_cmd_type;

   typedef struct packed {
      logic len_bad;
      logic msg_ok;
      logic esc_now;
      logic size_ge;
      logic rem_zero;
      logic rem_one;
      logic cnt_end3;
      logic cnt_end15;
      logic out_free;
   } dp_stat_type;

endpackage
`default_nettype wire

### sv/sei_dp.sv
`default_nettype none
module sei_dp import sei_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire dp_cmd_type            cmd,
   output dp_stat_type                stat,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [7:0]                 rsp_tdata,
   output logic                       rsp_tlast,
   output logic [1:0]                 rsp_tuser
);

   logic [LEN_W-1:0]  len_in;
   logic [7:0]        data_in;
   logic [31:0]       uuid_ff [4];
   logic [31:0]       uuid_word;
   logic [7:0]        uuid_byte;
   logic [15:0]       hist_ff, hist_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic              open_ff, open_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [7:0]        data_ff, data_in_nx;
   logic              ovalid_ff, ovalid_in;
   logic [7:0]        obyte_ff, obyte_in;
   logic              olast_ff, olast_in;
   logic [1:0]        ostat_ff, ostat_in;
   logic [7:0]        cand;
   logic [7:0]        byte_out;
   logic              size_ge;
   logic              esc_now;
   logic              adv;

   assign data_in = req_tdata[7:0];
   assign len_in  = req_tdata[LEN_W+7:8];

   // uuid register file
   always_ff @(posedge clock) begin
      if (reset) begin
         uuid_ff[0] <= UUID0_RST;
         uuid_ff[1] <= UUID1_RST;
         uuid_ff[2] <= UUID2_RST;
         uuid_ff[3] <= UUID3_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_UUID0: uuid_ff[0] <= csr_wdata;
            REG_UUID1: uuid_ff[1] <= csr_wdata;
            REG_UUID2: uuid_ff[2] <= csr_wdata;
            REG_UUID3: uuid_ff[3] <= csr_wdata;
         endcase
      end
   end

   // uuid byte pick, big-endian within a word
   assign uuid_word = uuid_ff[cnt_ff[3:2]];
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    uuid_byte = uuid_word[31:24];
         2'd1:    uuid_byte = uuid_word[23:16];
         2'd2:    uuid_byte = uuid_word[15:8];
         default: uuid_byte = uuid_word[7:0];
      endcase
   end

   assign size_ge = size_ff >= SIZE_W'(255);

   // candidate byte for the current step
   always_comb begin
      case (cmd.src)
         SRC_START: cand = (cnt_ff[1:0] == 2'd3) ? BYTE_ONE : BYTE_ZERO;
         SRC_HDR:   cand = NAL_SEI;
         SRC_TYPE:  cand = SEI_UDU;
         SRC_SIZE:  cand = size_ge ? BYTE_FF : size_ff[7:0];
         SRC_UUID:  cand = uuid_byte;
         SRC_DATA:  cand = data_ff;
         SRC_TRAIL: cand = TRAIL;
         default:   cand = BYTE_ZERO;
      endcase
   end

   // emulation prevention: two zeros then a byte of 0..3 gets 0x03 first
   assign esc_now  = cmd.emit && cmd.esc && (hist_ff == 16'h0000) && (cand <= EPB);
   assign adv      = cmd.emit && !esc_now;
   assign byte_out = esc_now ? EPB : cand;

   // message state, history and counters
   always_comb begin
      hist_in    = hist_ff;
      rem_in     = rem_ff;
      open_in    = open_ff;
      size_in    = size_ff;
      cnt_in     = cnt_ff;
      data_in_nx = data_ff;
      if (cmd.cap_byte) begin
         data_in_nx = data_in;
      end
      if (cmd.cap_begin) begin
         rem_in  = len_in;
         open_in = (len_in != '0);
         size_in = SIZE_W'(len_in) + SIZE_W'(16);
      end
      if (cmd.emit && (cmd.status == ST_OK)) begin
         hist_in = {hist_ff[7:0], byte_out};
      end
      if (adv && cmd.size_step && size_ge) begin
         size_in = size_ff - SIZE_W'(255);
      end
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (adv && cmd.cnt_inc) begin
         cnt_in = cnt_ff + 4'd1;
      end
      if (adv && cmd.byte_done) begin
         rem_in = rem_ff - LEN_W'(1);
         if (rem_ff == LEN_W'(1)) begin
            open_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= 16'hFFFF;
         rem_ff  <= '0;
         open_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         hist_ff <= hist_in;
         rem_ff  <= rem_in;
         open_ff <= open_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff <= size_in;
      data_ff <= data_in_nx;
   end

   // output register
   always_comb begin
      ovalid_in = ovalid_ff;
      obyte_in  = obyte_ff;
      olast_in  = olast_ff;
      ostat_in  = ostat_ff;
      if (cmd.emit) begin
         ovalid_in = 1'b1;
         obyte_in  = byte_out;
         olast_in  = cmd.last && !esc_now;
         ostat_in  = cmd.status;
      end else if (rsp_tready) begin
         ovalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else begin
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      obyte_ff <= obyte_in;
      olast_ff <= olast_in;
      ostat_ff <= ostat_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = obyte_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tuser  = ostat_ff;

   // status to the controller
   assign stat.len_bad   = {21'd0, len_in} > 32'(MAX_PAYLOAD);
   assign stat.msg_ok    = open_ff && (rem_ff != '0);
   assign stat.esc_now   = esc_now;
   assign stat.size_ge   = size_ge;
   assign stat.rem_zero  = (rem_ff == '0);
   assign stat.rem_one   = (rem_ff == LEN_W'(1));
   assign stat.cnt_end3  = (cnt_ff[1:0] == 2'd3);
   assign stat.cnt_end15 = (cnt_ff == 4'd15);
   assign stat.out_free  = !ovalid_ff || rsp_tready;

endmodule
`default_nettype wire

### sv/sei_ctrl.sv
`default_nettype none
module sei_ctrl import sei_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic        req_tuser,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   state_type state_ff, state_in;
   logic      go;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a step completes when its real byte (not an escape) goes out
   assign go = stat.out_free && !stat.esc_now;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.status = ST_OK;
      cmd.src    = SRC_ERR;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.cap_byte = 1'b1;
               if (req_tuser == ACT_BEGIN) begin
                  if (stat.len_bad) begin
                     state_in = S_ERR_LEN;
                  end else begin
                     cmd.cap_begin = 1'b1;
                     cmd.cnt_clr   = 1'b1;
                     state_in      = S_START;
                  end
               end else if (stat.msg_ok) begin
                  state_in = S_DATA;
               end else begin
                  state_in = S_ERR_MSG;
               end
            end
         end
         S_START: begin
            cmd.src  = SRC_START;
            cmd.emit = stat.out_free;
            if (stat.out_free) begin
               if (stat.cnt_end3) begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = S_HDR;
               end else begin
                  cmd.cnt_inc = 1'b1;
               end
            end
         end
         S_HDR: begin
            cmd.src  = SRC_HDR;
            cmd.esc  = 1'b1;
            cmd.emit = stat.out_free;
            if (go) begin
               state_in = S_TYPE;
            end
         end
         S_TYPE: begin
            cmd.src  = SRC_TYPE;
            cmd.esc  = 1'b1;
            cmd.emit = stat.out_free;
            if (go) begin
               state_in = S_SIZE;
            end
         end
         S_SIZE: begin
            cmd.src       = SRC_SIZE;
            cmd.esc       = 1'b1;
            cmd.emit      = stat.out_free;
            cmd.size_step = 1'b1;
            if (go && !stat.size_ge) begin
               state_in = S_UUID;
            end
         end
         S_UUID: begin
            cmd.src     = SRC_UUID;
            cmd.esc     = 1'b1;
            cmd.emit    = stat.out_free;
            cmd.cnt_inc = 1'b1;
            cmd.last    = stat.cnt_end15 && !stat.rem_zero;
            if (go && stat.cnt_end15) begin
               state_in = stat.rem_zero ? S_TRAIL : S_IDLE;
            end
         end
         S_DATA: begin
            cmd.src       = SRC_DATA;
            cmd.esc       = 1'b1;
            cmd.emit      = stat.out_free;
            cmd.byte_done = 1'b1;
            cmd.last      = !stat.rem_one;
            if (go) begin
               state_in = stat.rem_one ? S_TRAIL : S_IDLE;
            end
         end
         S_TRAIL: begin
            cmd.src  = SRC_TRAIL;
            cmd.esc  = 1'b1;
            cmd.emit = stat.out_free;
            cmd.last = 1'b1;
            if (go) begin
               state_in = S_IDLE;
            end
         end
         S_ERR_LEN: begin
            cmd.status = ST_LEN;
            cmd.emit   = stat.out_free;
            cmd.last   = 1'b1;
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         S_ERR_MSG: begin
            cmd.status = ST_NOMSG;
            cmd.emit   = stat.out_free;
            cmd.last   = 1'b1;
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

### sv/sei_nal_unit_builder_top.sv
`default_nettype none
// channel  direction  fields
// req      in         tuser: action; tdata: data_byte [7:0], message_length [18:8]
// rsp      out        tdata: out_byte; tlast: last; tuser: status
// csr      in         write only: uuid_word0..3 at index 0..3
//
// a request is taken while idle, then its results go out one byte per cycle:
// a payload byte as an optional escape and its byte, the last adding the trailing
// byte; a begin as start code, header, type, size and uuid bytes, escapes and an
// optional trailing byte; the rate is set by the single output byte register
// reset is synchronous; an output stall holds the sequencer on its current byte
// the next request is taken once the last result is in the output register
module sei_nal_unit_builder_top import sei_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // data_byte, message_length, pad
   input  wire logic                  req_tuser,   // action
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [7:0]                 rsp_tdata,   // out_byte
   output logic                       rsp_tlast,
   output logic [1:0]                 rsp_tuser,   // status
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer
   sei_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   // byte datapath
   sei_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

### sv/sei_chk.sv
`default_nettype none
module sei_chk import sei_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [7:0]            rsp_tdata,
   input wire logic                  rsp_tlast,
   input wire logic [1:0]            rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // an error result is a zero byte that ends the request
   a_err_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> (rsp_tdata == 8'h00) && rsp_tlast)
      else $error("malformed error result");

   // only defined status codes appear
   a_stat_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ST_OK) || (rsp_tuser == ST_LEN) ||
                     (rsp_tuser == ST_NOMSG))
      else $error("undefined status code");

   // a taken request keeps the input closed while its results are produced
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

endmodule

bind sei_nal_unit_builder_top sei_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
